// ----- rtl/core/tts_pkg.sv -----
// thread table scheduler: shared constants, slot record and state codes
// no dependencies
`timescale 1ns / 1ps

package tts_pkg;

  localparam int MAX_THREADS = 32;
  localparam int IDX_W       = $clog2(MAX_THREADS);
  localparam int CNT_W       = $clog2(MAX_THREADS + 1);
  localparam int TIME_W      = 48;

  typedef enum logic [1:0] {
    ST_READY    = 2'd0,
    ST_WAITING  = 2'd1,
    ST_SLEEPING = 2'd2,
    ST_ENDED    = 2'd3
  } slot_st_t;

  typedef enum logic [2:0] {
    OP_CREATE  = 3'd0,
    OP_PICK    = 3'd1,
    OP_EXIT    = 3'd2,
    OP_WAIT    = 3'd3,
    OP_SLEEP   = 3'd4,
    OP_ELAPSED = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_FULL   = 2'd1,
    STS_ENDED  = 2'd2,
    STS_NONE   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_PREP,
    FSM_PASS_A,
    FSM_PASS_B,
    FSM_DONE
  } fsm_t;

  typedef struct packed {
    slot_st_t           st;
    logic [IDX_W-1:0]   waited;
    logic [TIME_W-1:0]  sleep;
  } slot_t;

endpackage

// ----- rtl/core/tts_cell.sv -----
// thread table scheduler: one slot cell of the rotating ring
// depends on tts_pkg
`timescale 1ns / 1ps

module tts_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          shift_en,
  input  tts_pkg::slot_t d,
  output tts_pkg::slot_t q
);

  tts_pkg::slot_t slot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r.st     <= tts_pkg::ST_ENDED;
      slot_r.waited <= '0;
      slot_r.sleep  <= '0;
    end else if (shift_en) begin
      slot_r <= d;
    end
  end

  assign q = slot_r;

endmodule

// ----- rtl/core/tts_ctrl.sv -----
// thread table scheduler: sequencer, per-slot update at the ring head, result register
// depends on tts_pkg
`timescale 1ns / 1ps

module tts_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    in_operation,
  input  logic [4:0]                    in_target,
  input  logic [47:0]                   in_duration_ns,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [4:0]                    out_chosen_slot,
  output logic                          out_chosen_valid,
  output logic [47:0]                   out_wake_in_ns,
  output logic [1:0]                    out_status_code,
  output logic                          shift_en,
  input  tts_pkg::slot_t                head,
  output tts_pkg::slot_t                wb
);

  localparam int IW = tts_pkg::IDX_W;
  localparam int CW = tts_pkg::CNT_W;
  localparam int TW = tts_pkg::TIME_W;

  tts_pkg::fsm_t state_r, state_nxt;

  logic [2:0]     op_r;
  logic [IW-1:0]  tgt_r;
  logic [TW-1:0]  dur_r;
  logic [CW-1:0]  live_r;
  logic [IW-1:0]  run_r;
  logic [CW-1:0]  start_r;
  logic [IW-1:0]  cnt_r;
  tts_pkg::slot_st_t run_st_r, tgt_st_r;
  tts_pkg::slot_t last_r;
  logic           hi_f_r, lo_f_r;
  logic [IW-1:0]  hi_r, lo_r;
  logic           any_r;
  logic [TW-1:0]  min_r;

  logic           out_valid_r;
  logic [4:0]     chosen_r;
  logic           cvalid_r;
  logic [47:0]    wake_r;
  logic [1:0]     status_r;

  logic [IW-1:0]  last_idx;
  logic           in_live, cur_live;
  logic           create_ok, exit_ok, wait_ok;
  logic           pick_found;
  logic [IW-1:0]  pick_idx;
  tts_pkg::slot_t src, v;
  logic           load_out;
  logic [1:0]     status_c;

  assign last_idx  = IW'(live_r - CW'(1));
  assign in_live   = {1'b0, cnt_r} < live_r;
  assign cur_live  = (live_r != '0) && ({1'b0, run_r} < live_r);
  assign create_ok = live_r != CW'(tts_pkg::MAX_THREADS);
  assign exit_ok   = cur_live && (run_st_r != tts_pkg::ST_ENDED);
  assign wait_ok   = cur_live && ({1'b0, tgt_r} < live_r) && (tgt_st_r != tts_pkg::ST_ENDED);
  assign pick_found = hi_f_r || lo_f_r;
  assign pick_idx   = hi_f_r ? hi_r : lo_r;

  // per-slot update at the ring head
  always_comb begin
    src = head;
    v   = head;
    case (op_r)
      tts_pkg::OP_CREATE: begin
        if (create_ok && ({1'b0, cnt_r} == live_r)) begin
          v.st = tts_pkg::ST_READY;
          v.waited = '0;
          v.sleep = '0;
        end
      end
      tts_pkg::OP_EXIT: begin
        if (exit_ok && in_live) begin
          if ((cnt_r == run_r) && (run_r != last_idx)) src = last_r;
          v = src;
          if ((src.st == tts_pkg::ST_WAITING) && (src.waited == run_r)) begin
            v.st = tts_pkg::ST_READY;
            v.waited = '0;
          end
          if ((run_r != last_idx) && (cnt_r < last_idx) &&
              (v.st == tts_pkg::ST_WAITING) && (v.waited == last_idx)) begin
            v.waited = run_r;
          end
          if (cnt_r == last_idx) begin
            v.st = tts_pkg::ST_ENDED;
            v.waited = '0;
            v.sleep = '0;
          end
        end
      end
      tts_pkg::OP_WAIT: begin
        if (wait_ok && (cnt_r == run_r) && (run_st_r == tts_pkg::ST_READY)) begin
          v.st = tts_pkg::ST_WAITING;
          v.waited = tgt_r;
        end
      end
      tts_pkg::OP_SLEEP: begin
        if (cur_live && (cnt_r == run_r)) begin
          if (dur_r == '0) begin
            v.st = tts_pkg::ST_READY;
            v.sleep = '0;
          end else begin
            v.st = tts_pkg::ST_SLEEPING;
            v.sleep = dur_r;
          end
        end
      end
      tts_pkg::OP_ELAPSED: begin
        if (in_live && (head.st == tts_pkg::ST_SLEEPING)) begin
          if (head.sleep <= dur_r) begin
            v.st = tts_pkg::ST_READY;
            v.sleep = '0;
          end else begin
            v.sleep = head.sleep - dur_r;
          end
        end
      end
      default: begin
        v = head;
      end
    endcase
  end

  assign shift_en = (state_r == tts_pkg::FSM_PASS_A) || (state_r == tts_pkg::FSM_PASS_B);
  assign wb       = (state_r == tts_pkg::FSM_PASS_B) ? v : head;
  assign load_out = (state_r == tts_pkg::FSM_DONE) && (!out_valid_r || out_ready);
  assign in_ready = state_r == tts_pkg::FSM_IDLE;

  always_comb begin
    status_c = tts_pkg::STS_OK;
    case (op_r)
      tts_pkg::OP_CREATE: if (!create_ok) status_c = tts_pkg::STS_FULL;
      tts_pkg::OP_PICK:   if (!pick_found) status_c = tts_pkg::STS_NONE;
      tts_pkg::OP_EXIT: begin
        if (live_r == '0)  status_c = tts_pkg::STS_NONE;
        else if (!exit_ok) status_c = tts_pkg::STS_ENDED;
      end
      tts_pkg::OP_WAIT: begin
        if (!cur_live)     status_c = tts_pkg::STS_NONE;
        else if (!wait_ok) status_c = tts_pkg::STS_ENDED;
      end
      tts_pkg::OP_SLEEP:  if (!cur_live) status_c = tts_pkg::STS_NONE;
      default:            status_c = tts_pkg::STS_OK;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tts_pkg::FSM_IDLE:   if (in_valid) state_nxt = tts_pkg::FSM_PREP;
      tts_pkg::FSM_PREP: begin
        if (!((live_r != '0) && (start_r >= live_r))) state_nxt = tts_pkg::FSM_PASS_A;
      end
      tts_pkg::FSM_PASS_A: if (cnt_r == IW'(tts_pkg::MAX_THREADS - 1)) state_nxt = tts_pkg::FSM_PASS_B;
      tts_pkg::FSM_PASS_B: if (cnt_r == IW'(tts_pkg::MAX_THREADS - 1)) state_nxt = tts_pkg::FSM_DONE;
      tts_pkg::FSM_DONE:   if (load_out) state_nxt = tts_pkg::FSM_IDLE;
      default:             state_nxt = tts_pkg::FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tts_pkg::FSM_IDLE;
      live_r      <= '0;
      run_r       <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      case (state_r)
        tts_pkg::FSM_IDLE: begin
          if (in_valid) begin
            op_r    <= in_operation;
            tgt_r   <= in_target;
            dur_r   <= in_duration_ns;
            start_r <= {1'b0, run_r} + CW'(1);
            cnt_r   <= '0;
            hi_f_r  <= 1'b0;
            lo_f_r  <= 1'b0;
            any_r   <= 1'b0;
            min_r   <= '0;
          end
        end
        tts_pkg::FSM_PREP: begin
          if ((live_r != '0) && (start_r >= live_r)) start_r <= start_r - live_r;
        end
        tts_pkg::FSM_PASS_A: begin
          cnt_r <= cnt_r + IW'(1);
          if (cnt_r == run_r)    run_st_r <= head.st;
          if (cnt_r == tgt_r)    tgt_st_r <= head.st;
          if (cnt_r == last_idx) last_r   <= head;
          if (in_live && (head.st == tts_pkg::ST_READY)) begin
            if (!hi_f_r && ({1'b0, cnt_r} >= start_r)) begin
              hi_f_r <= 1'b1;
              hi_r   <= cnt_r;
            end
            if (!lo_f_r) begin
              lo_f_r <= 1'b1;
              lo_r   <= cnt_r;
            end
          end
        end
        tts_pkg::FSM_PASS_B: begin
          cnt_r <= cnt_r + IW'(1);
          if ((v.st == tts_pkg::ST_SLEEPING) && (!any_r || (v.sleep < min_r))) begin
            any_r <= 1'b1;
            min_r <= v.sleep;
          end
        end
        tts_pkg::FSM_DONE: begin
          if (load_out) begin
            status_r    <= status_c;
            wake_r      <= any_r ? 48'(min_r) : 48'd0;
            if ((op_r == tts_pkg::OP_CREATE) && create_ok) begin
              chosen_r <= 5'(live_r);
              cvalid_r <= 1'b1;
              live_r   <= live_r + CW'(1);
            end else if ((op_r == tts_pkg::OP_PICK) && pick_found) begin
              chosen_r <= 5'(pick_idx);
              cvalid_r <= 1'b1;
              run_r    <= pick_idx;
            end else begin
              chosen_r <= '0;
              cvalid_r <= 1'b0;
              if ((op_r == tts_pkg::OP_EXIT) && exit_ok) live_r <= live_r - CW'(1);
            end
          end
        end
        default: begin
          cnt_r <= '0;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_chosen_slot  = chosen_r;
  assign out_chosen_valid = cvalid_r;
  assign out_wake_in_ns   = wake_r;
  assign out_status_code  = status_r;

endmodule

// ----- rtl/core/thread_table_scheduler_top.sv -----
// thread table scheduler: top level, ring of slot cells and the sequencer
// per beat: a prep state that wraps the round-robin start back into the table,
// then two full ring rotations (a scan pass and an update pass), then the result register
// beats are handled one at a time; a new beat is taken only after the last result is loaded
// reset: synchronous active-low rst_n; all slots ended, table empty, running slot 0
`timescale 1ns / 1ps

module thread_table_scheduler_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_operation,
  input  logic [4:0]  in_target,
  input  logic [47:0] in_duration_ns,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_chosen_slot,
  output logic        out_chosen_valid,
  output logic [47:0] out_wake_in_ns,
  output logic [1:0]  out_status_code
);

  localparam int N = tts_pkg::MAX_THREADS;

  tts_pkg::slot_t ring_q [N];
  tts_pkg::slot_t wb;
  logic           shift_en;

  genvar k;
  generate
    for (k = 0; k < N; k++) begin : g_cell
      tts_pkg::slot_t d;
      if (k == N - 1) begin : g_tail
        assign d = wb;
      end else begin : g_mid
        assign d = ring_q[k+1];
      end
      tts_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .d        (d),
        .q        (ring_q[k])
      );
    end
  endgenerate

  tts_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_target        (in_target),
    .in_duration_ns   (in_duration_ns),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_chosen_slot  (out_chosen_slot),
    .out_chosen_valid (out_chosen_valid),
    .out_wake_in_ns   (out_wake_in_ns),
    .out_status_code  (out_status_code),
    .shift_en         (shift_en),
    .head             (ring_q[0]),
    .wb               (wb)
  );

endmodule

// ----- tb/testbench.sv -----
// thread table scheduler testbench: directed and random operation beats
// checked against an in-bench table model; depends on tts_pkg and the top
`timescale 1ns / 1ps

module testbench;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_operation;
  logic [4:0]  in_target;
  logic [47:0] in_duration_ns;
  logic        out_valid;
  logic        out_ready;
  logic [4:0]  out_chosen_slot;
  logic        out_chosen_valid;
  logic [47:0] out_wake_in_ns;
  logic [1:0]  out_status_code;

  typedef struct packed {
    logic [4:0]  slot;
    logic        slot_ok;
    logic [47:0] wake;
    logic [1:0]  status;
  } sched_res_t;

  thread_table_scheduler_top u_dut (.*);

  tts_pkg::slot_st_t tbl_st[tts_pkg::MAX_THREADS];
  logic [4:0]  tbl_wait[tts_pkg::MAX_THREADS];
  logic [47:0] tbl_sleep[tts_pkg::MAX_THREADS];
  int          n_live;
  int          cur_slot;
  sched_res_t  expected_q[$];
  int          errors;
  bit          rx_busy;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  function automatic void table_reset();
    for (int i = 0; i < tts_pkg::MAX_THREADS; i++) begin
      tbl_st[i] = tts_pkg::ST_ENDED;
      tbl_wait[i] = '0;
      tbl_sleep[i] = '0;
    end
    n_live = 0;
    cur_slot = 0;
  endfunction

  function automatic sched_res_t schedule_step(logic [2:0] op, logic [4:0] tgt,
                                               logic [47:0] dur);
    sched_res_t r;
    bit cur_live;
    int idx;
    int last;
    bit any;
    r = '0;
    cur_live = n_live > 0 && cur_slot < n_live;
    case (op)
      tts_pkg::OP_CREATE: begin
        if (n_live >= tts_pkg::MAX_THREADS) r.status = tts_pkg::STS_FULL;
        else begin
          tbl_st[n_live] = tts_pkg::ST_READY;
          tbl_wait[n_live] = '0;
          tbl_sleep[n_live] = '0;
          r.slot = 5'(n_live);
          r.slot_ok = 1'b1;
          n_live++;
        end
      end
      tts_pkg::OP_PICK: begin
        r.status = tts_pkg::STS_NONE;
        idx = cur_slot;
        for (int i = 0; i < n_live; i++) begin
          idx = (idx + 1) % n_live;
          if (tbl_st[idx] == tts_pkg::ST_READY) begin
            cur_slot = idx;
            r.slot = 5'(idx);
            r.slot_ok = 1'b1;
            r.status = tts_pkg::STS_OK;
            break;
          end
        end
      end
      tts_pkg::OP_EXIT: begin
        if (n_live == 0) r.status = tts_pkg::STS_NONE;
        else if (!cur_live || tbl_st[cur_slot] == tts_pkg::ST_ENDED)
          r.status = tts_pkg::STS_ENDED;
        else begin
          last = n_live - 1;
          for (int i = 0; i < n_live; i++)
            if (tbl_st[i] == tts_pkg::ST_WAITING && tbl_wait[i] == cur_slot) begin
              tbl_st[i] = tts_pkg::ST_READY;
              tbl_wait[i] = '0;
            end
          if (cur_slot != last) begin
            tbl_st[cur_slot] = tbl_st[last];
            tbl_wait[cur_slot] = tbl_wait[last];
            tbl_sleep[cur_slot] = tbl_sleep[last];
            for (int i = 0; i < last; i++)
              if (tbl_st[i] == tts_pkg::ST_WAITING && tbl_wait[i] == last)
                tbl_wait[i] = 5'(cur_slot);
          end
          tbl_st[last] = tts_pkg::ST_ENDED;
          tbl_wait[last] = '0;
          tbl_sleep[last] = '0;
          n_live = last;
        end
      end
      tts_pkg::OP_WAIT: begin
        if (!cur_live) r.status = tts_pkg::STS_NONE;
        else if (tgt >= n_live || tbl_st[tgt] == tts_pkg::ST_ENDED)
          r.status = tts_pkg::STS_ENDED;
        else if (tbl_st[cur_slot] == tts_pkg::ST_READY) begin
          tbl_st[cur_slot] = tts_pkg::ST_WAITING;
          tbl_wait[cur_slot] = tgt;
        end
      end
      tts_pkg::OP_SLEEP: begin
        if (!cur_live) r.status = tts_pkg::STS_NONE;
        else begin
          tbl_sleep[cur_slot] = dur;
          tbl_st[cur_slot] = (dur == 0) ? tts_pkg::ST_READY : tts_pkg::ST_SLEEPING;
        end
      end
      tts_pkg::OP_ELAPSED: begin
        for (int i = 0; i < n_live; i++)
          if (tbl_st[i] == tts_pkg::ST_SLEEPING) begin
            if (tbl_sleep[i] <= dur) begin
              tbl_sleep[i] = '0;
              tbl_st[i] = tts_pkg::ST_READY;
            end else tbl_sleep[i] = tbl_sleep[i] - dur;
          end
      end
      default: ;
    endcase
    any = 1'b0;
    for (int i = 0; i < n_live; i++)
      if (tbl_st[i] == tts_pkg::ST_SLEEPING && (!any || tbl_sleep[i] < r.wake)) begin
        r.wake = tbl_sleep[i];
        any = 1'b1;
      end
    return r;
  endfunction

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_op(logic [2:0] op, logic [4:0] tgt, logic [47:0] dur);
    int g;
    g = gap_len();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_target <= tgt;
    in_duration_ns <= dur;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.push_back(schedule_step(op, tgt, dur));
    @(negedge clk);
  endtask

  // result side: random stalls, compare at the rising edge
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= rx_busy ? 1'b0 : 1'b1;
    end
  end

  initial begin
    rx_busy = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 19) == 0) begin
        rx_busy = 1'b1;
        repeat (gap_len()) @(negedge clk);
        rx_busy = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    sched_res_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result beat with nothing expected, actual %h/%b/%h/%h", $time,
                 out_chosen_slot, out_chosen_valid, out_wake_in_ns, out_status_code);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_chosen_slot !== e.slot) begin
          $display("%0t: chosen_slot expected %0d actual %0d", $time, e.slot, out_chosen_slot);
          errors++;
        end
        if (out_chosen_valid !== e.slot_ok) begin
          $display("%0t: chosen_valid expected %0d actual %0d", $time, e.slot_ok,
                   out_chosen_valid);
          errors++;
        end
        if (out_wake_in_ns !== e.wake) begin
          $display("%0t: wake_in_ns expected %0d actual %0d", $time, e.wake, out_wake_in_ns);
          errors++;
        end
        if (out_status_code !== e.status) begin
          $display("%0t: status_code expected %0d actual %0d", $time, e.status,
                   out_status_code);
          errors++;
        end
      end
    end
  end

  function automatic logic [47:0] rand_dur();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 48'hFFFF_FFFF_FFFF;
      2: return 48'({$urandom, $urandom});
      default: return 48'($urandom_range(1, 3000));
    endcase
  endfunction

  task automatic test_empty_table();
    send_op(tts_pkg::OP_PICK, 5'd0, '0);
    send_op(tts_pkg::OP_EXIT, 5'd0, '0);
    send_op(tts_pkg::OP_WAIT, 5'd31, '0);
    send_op(tts_pkg::OP_SLEEP, 5'd0, 48'd5);
    send_op(tts_pkg::OP_ELAPSED, 5'd0, 48'hFFFF_FFFF_FFFF);
    send_op(3'd6, 5'd31, 48'hFFFF_FFFF_FFFF);
    send_op(3'd7, 5'd0, '0);
  endtask

  task automatic test_basic_ops();
    send_op(tts_pkg::OP_CREATE, 5'd0, '0);
    send_op(tts_pkg::OP_CREATE, 5'd0, '0);
    send_op(tts_pkg::OP_CREATE, 5'd0, '0);
    send_op(tts_pkg::OP_WAIT, 5'd31, '0);
    send_op(tts_pkg::OP_WAIT, 5'd0, '0);
    send_op(tts_pkg::OP_WAIT, 5'd1, '0);
    send_op(tts_pkg::OP_PICK, 5'd0, '0);
    send_op(tts_pkg::OP_SLEEP, 5'd0, 48'hFFFF_FFFF_FFFF);
    send_op(tts_pkg::OP_PICK, 5'd0, '0);
    send_op(tts_pkg::OP_SLEEP, 5'd0, '0);
    send_op(tts_pkg::OP_SLEEP, 5'd0, 48'd100);
    send_op(tts_pkg::OP_PICK, 5'd0, '0);
    send_op(tts_pkg::OP_ELAPSED, 5'd0, 48'd100);
    send_op(tts_pkg::OP_EXIT, 5'd0, '0);
    send_op(tts_pkg::OP_EXIT, 5'd0, '0);
  endtask

  task automatic test_full_table();
    for (int i = 0; i < tts_pkg::MAX_THREADS + 2; i++) send_op(tts_pkg::OP_CREATE, '0, '0);
  endtask

  task automatic test_random_ops(int count);
    logic [2:0] op;
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 18) op = (n_live < 28 || r < 4) ? tts_pkg::OP_CREATE : tts_pkg::OP_EXIT;
      else if (r < 40) op = tts_pkg::OP_PICK;
      else if (r < 54) op = tts_pkg::OP_EXIT;
      else if (r < 68) op = tts_pkg::OP_WAIT;
      else if (r < 82) op = tts_pkg::OP_SLEEP;
      else if (r < 97) op = tts_pkg::OP_ELAPSED;
      else op = 3'($urandom_range(6, 7));
      send_op(op, (n_live > 0 && $urandom_range(0, 7) != 0) ?
              5'($urandom_range(0, n_live - 1)) : 5'($urandom), rand_dur());
    end
  endtask

  initial begin
    errors = 0;
    table_reset();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = '0;
    in_target = '0;
    in_duration_ns = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_empty_table();
    test_basic_ops();
    test_full_table();
    test_random_ops(350);
    for (int i = 0; i < tts_pkg::MAX_THREADS; i++) send_op(tts_pkg::OP_EXIT, '0, '0);
    test_random_ops(300);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

endmodule
